// ===== sv/modular_inverse_euclid_core_defines.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef MODULAR_INVERSE_EUCLID_CORE_DEFINES_SVH
`define MODULAR_INVERSE_EUCLID_CORE_DEFINES_SVH

// same-cycle implication under the active-low reset
`define MINV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under the active-low reset
`define MINV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/minv_pkg.sv =====
// package for the modular inverse core: sequencer states and reset constant
// no dependencies
package minv_pkg;

    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_STEP,
        ST_FINISH
    } minv_state_t;

endpackage

// ===== sv/minv_divstep.sv =====
// shared shift-subtract divider, one quotient bit per cycle
// also accumulates quotient times a signed multiplier by shift-add
// depends on minv_pkg
module minv_divstep
    import minv_pkg::*;
#(
    parameter int W  = 31,
    parameter int CW = 33
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [W-1:0]  divisor,
    input  logic [CW-1:0] mult,
    output logic          done,
    output logic [W-1:0]  remainder,
    output logic [CW-1:0] product
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     dvd_reg, dvd_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [CW-1:0]    mul_reg, mul_next;
    logic [CW-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [W:0]       cand;
    logic             ge;

    always_comb
    begin
        cand      = {rem_reg, dvd_reg[W-1]};
        ge        = (cand >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        mul_next  = mul_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            dvd_next = dividend;
            dsr_next = divisor;
            mul_next = mult;
            acc_next = '0;
            cnt_next = CNT_W'(W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? W'(cand - {1'b0, dsr_reg}) : cand[W-1:0];
            dvd_next  = {dvd_reg[W-2:0], 1'b0};
            acc_next  = {acc_reg[CW-2:0], 1'b0} + (ge ? mul_reg : '0);
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        mul_reg <= mul_next;
        acc_reg <= acc_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;
    assign product   = acc_reg;

endmodule

// ===== sv/modular_inverse_euclid_core.sv =====
// Modular inverse core: returns the inverse of each operand modulo the
// configured modulus by the extended Euclidean algorithm, one transfer out
// for each transfer in. The operand is first reduced, then every Euclid
// step runs through one shared shift-subtract divider that makes one
// quotient bit per cycle and builds quotient times coefficient alongside.
// Each divider pass is followed by a check of the new remainder, and a
// stalled output transfer holds the core until it is taken. s_tready is
// high only while no item is in work. The result is 0 when the operand
// is a multiple of the modulus or the modulus is zero. A non-prime
// modulus is not flagged: the Bezout coefficient comes back made
// non-negative.
// depends on minv_pkg and minv_divstep
module modular_inverse_euclid_core
    import minv_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wen,
    input  logic [VALUE_BITS-1:0] cfg_wdata,  // modulus
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // operand, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata     // inverse, zero pad
);

    localparam int W  = VALUE_BITS;
    localparam int CW = VALUE_BITS + 2;

    minv_state_t   state_reg, state_next;
    logic [W-1:0]  modulus_reg;
    logic [W-1:0]  num_reg, num_next;
    logic [W-1:0]  den_reg, den_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [W-1:0]  res_reg, res_next;
    logic [W-1:0]  out_reg, out_next;
    logic          m_tvalid_reg, m_tvalid_next;

    logic          div_start;
    logic [W-1:0]  div_dividend;
    logic [W-1:0]  div_divisor;
    logic [CW-1:0] div_mult;
    logic          div_done;
    logic [W-1:0]  div_rem;
    logic [CW-1:0] div_prod;
    logic [CW-1:0] prev_fixed;

    minv_divstep #(
        .W  (W),
        .CW (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .mult      (div_mult),
        .done      (div_done),
        .remainder (div_rem),
        .product   (div_prod)
    );

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        num_next      = num_reg;
        den_next      = den_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        div_start     = 1'b0;
        div_dividend  = num_reg;
        div_divisor   = den_reg;
        div_mult      = cur_reg;
        prev_fixed    = prev_reg[CW-1] ? (prev_reg + CW'(modulus_reg)) : prev_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                div_dividend = s_tdata[W-1:0];
                div_divisor  = modulus_reg;
                div_mult     = '0;
                if (s_tvalid)
                begin
                    num_next  = modulus_reg;
                    prev_next = '0;
                    cur_next  = CW'(1);
                    if (modulus_reg == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (div_done)
                begin
                    den_next   = div_rem;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (den_reg == '0)
                begin
                    res_next   = prev_fixed[W-1:0];
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (div_done)
                begin
                    prev_next  = cur_reg;
                    cur_next   = prev_reg - div_prod;
                    num_next   = den_reg;
                    den_next   = div_rem;
                    state_next = ST_CHECK;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            modulus_reg  <= MODULUS_RESET[W-1:0];
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wen)
            begin
                modulus_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        prev_reg <= prev_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(out_reg);

endmodule

// ===== sv/minv_checker.sv =====
// port-level checker for the modular inverse core, bound to the top level
// depends on modular_inverse_euclid_core_defines.svh and minv_pkg
`include "modular_inverse_euclid_core_defines.svh"

module minv_checker
    import minv_pkg::*;
#(
    parameter int VALUE_BITS = 31,
    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    `MINV_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // one item in work at a time
    `MINV_ASSERT_NXT(a_busy_after_in, clk, rst_n, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // a fresh result appears only as the core returns to idle
    `MINV_ASSERT_IMP(a_idle_on_result, clk, rst_n, $rose(m_tvalid), s_tready, "result without idle")

endmodule

bind modular_inverse_euclid_core minv_checker #(.VALUE_BITS(VALUE_BITS)) u_minv_checker (.*);

// ===== verif/tb.sv =====
// testbench for modular_inverse_euclid_core: directed table then random phases of modulus
// writes and operand streams, each result checked against a known value or an extended euclid predictor
// depends on minv_pkg and modular_inverse_euclid_core
module tb;
    import minv_pkg::*;

    localparam int VALUE_BITS = 31;
    localparam int TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 1;
    localparam int RANDOM_ITEMS = 1680;
    localparam int HOLDOFF_CYCLES = 800;
    localparam int DRAIN_CYCLES = 1600;
    localparam longint unsigned CYCLE_LIMIT = 10000000;
    localparam int MAX_REPORTS = 10;
    localparam int N_ROWS = 28;

    typedef logic [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_KNOWN,
        ROW_PREDICT
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        value_t    value;
        value_t    result;
    } dir_row_t;

    typedef struct packed {
        value_t operand;
        value_t modulus;
        value_t inverse;
    } inverse_entry_t;

    typedef enum logic [2:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_MOSTLY,
        RX_PERIODIC,
        RX_SPARSE
    } rx_mode_t;

    localparam value_t CORNER_MODULI [6] = '{
        31'd0, 31'd1, 31'd2, 31'h7fffffff, value_t'(MODULUS_RESET), 31'd65521
    };

    // reset modulus first, then max prime, composite, one, zero, two
    localparam dir_row_t DIRECTED_ROWS [N_ROWS] = '{
        '{ROW_KNOWN,   31'd0,          31'd0},
        '{ROW_KNOWN,   31'd1,          31'd1},
        '{ROW_KNOWN,   31'd2,          31'd500000004},
        '{ROW_KNOWN,   31'd1000000006, 31'd1000000006},
        '{ROW_KNOWN,   31'd1000000007, 31'd0},
        '{ROW_KNOWN,   31'd2000000014, 31'd0},
        '{ROW_PREDICT, 31'h7fffffff,   31'd0},
        '{ROW_PREDICT, 31'd1234567,    31'd0},
        '{ROW_WRITE,   31'h7fffffff,   31'd0},
        '{ROW_KNOWN,   31'h7ffffffe,   31'h7ffffffe},
        '{ROW_KNOWN,   31'h7fffffff,   31'd0},
        '{ROW_PREDICT, 31'h55555555,   31'd0},
        '{ROW_KNOWN,   31'd1,          31'd1},
        '{ROW_WRITE,   31'd12,         31'd0},
        '{ROW_PREDICT, 31'd8,          31'd0},
        '{ROW_KNOWN,   31'd5,          31'd5},
        '{ROW_PREDICT, 31'h7fffffff,   31'd0},
        '{ROW_WRITE,   31'd1,          31'd0},
        '{ROW_KNOWN,   31'd7,          31'd0},
        '{ROW_KNOWN,   31'h7fffffff,   31'd0},
        '{ROW_WRITE,   31'd0,          31'd0},
        '{ROW_KNOWN,   31'd123,        31'd0},
        '{ROW_KNOWN,   31'h7fffffff,   31'd0},
        '{ROW_KNOWN,   31'd0,          31'd0},
        '{ROW_WRITE,   31'd2,          31'd0},
        '{ROW_KNOWN,   31'd1,          31'd1},
        '{ROW_KNOWN,   31'd2,          31'd0},
        '{ROW_KNOWN,   31'd3,          31'd1}
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wen;
    logic [VALUE_BITS-1:0] cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;    // operand, zero pad
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;    // inverse, zero pad

    inverse_entry_t  pending_inverses [$];
    value_t          active_modulus;
    int unsigned     fail_count;
    int unsigned     burst_left;
    bit              steady_feed;
    int unsigned     holdoff_requests;
    int unsigned     holdoffs_done;
    longint unsigned cycle_count;

    int unsigned     rx_tick;
    rx_mode_t        rx_mode;

    int              row;
    int unsigned     sent;
    int unsigned     phase;
    int unsigned     phase_items;
    value_t          operand;

    modular_inverse_euclid_core #(
        .VALUE_BITS(VALUE_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic value_t predict_inverse(input value_t value, input value_t modulus);
        longint unsigned num;
        longint unsigned den;
        longint unsigned coef_prev;
        longint unsigned coef_cur;
        longint unsigned quo;
        longint unsigned rem;
        longint unsigned coef_next;
        if (modulus == '0)
        begin
            return '0;
        end
        num = 64'(modulus);
        den = 64'(value);
        den = den % num;
        coef_prev = 0;
        coef_cur = 1;
        while (den != 0)
        begin
            quo = num / den;
            rem = num % den;
            coef_next = coef_prev - quo * coef_cur;
            coef_prev = coef_cur;
            coef_cur = coef_next;
            num = den;
            den = rem;
        end
        if (coef_prev[63])
        begin
            coef_prev = coef_prev + 64'(modulus);
        end
        return coef_prev[VALUE_BITS-1:0];
    endfunction

    function automatic value_t pick_modulus();
        case ($urandom_range(0, 9))
            0, 1:    return CORNER_MODULI[$urandom_range(0, 5)];
            2, 3:    return value_t'($urandom) | 31'h40000000;
            4, 5:    return value_t'($urandom_range(1000, 65535));
            default: return value_t'($urandom_range(2, 1000));
        endcase
    endfunction

    function automatic value_t pick_operand(input value_t modulus);
        longint unsigned top;
        longint unsigned prod;
        int unsigned     scale;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return value_t'($urandom);
            4:
                return value_t'($urandom_range(0, 16));
            5:
            begin
                // exact multiple of the modulus
                if (modulus == '0)
                begin
                    return value_t'($urandom);
                end
                top = VALUE_MAX / modulus;
                scale = $urandom_range(32'(top), 0);
                prod = modulus * scale;
                return value_t'(prod);
            end
            6:
                return modulus + value_t'($urandom_range(0, 2)) - value_t'(1);
            7:
                return (modulus == '0) ? value_t'($urandom) : value_t'($urandom) % modulus;
            default:
                return value_t'($urandom) >> $urandom_range(0, VALUE_BITS - 1);
        endcase
    endfunction

    function automatic void report_failure(input string what, input inverse_entry_t want,
                                           input value_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s: operand %0d modulus %0d expected %0d actual %0d",
                     what, want.operand, want.modulus, want.inverse, got);
        end
    endfunction

    task automatic offer_operand(input value_t value, input value_t want);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= TDATA_W'(value);
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pending_inverses.push_back('{value, active_modulus, want});
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_inverses.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_modulus(input value_t value);
        wait_drained();
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_wen <= 1'b0;
        active_modulus = value;
        burst_left = 0;
    endtask

    // result side: stall patterns plus one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        rx_tick = 0;
        rx_mode = RX_ALWAYS;
        holdoffs_done = 0;
        forever
        begin
            @(negedge clk);
            if (holdoffs_done != holdoff_requests)
            begin
                holdoffs_done++;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            if (rx_tick % 256 == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 4));
            end
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_HALF:     m_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY:   m_tready <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: m_tready <= (rx_tick % 7 < 4);
                default:     m_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_inverses.size() == 0)
            begin
                report_failure("unexpected transfer", '0, m_tdata[VALUE_BITS-1:0]);
            end
            else if (m_tdata[VALUE_BITS-1:0] !== pending_inverses[0].inverse)
            begin
                report_failure("inverse mismatch", pending_inverses.pop_front(),
                               m_tdata[VALUE_BITS-1:0]);
            end
            else
            begin
                void'(pending_inverses.pop_front());
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        fail_count = 0;
        burst_left = 0;
        steady_feed = 1'b0;
        holdoff_requests = 0;
        active_modulus = value_t'(MODULUS_RESET);
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < N_ROWS; row++)
        begin
            case (DIRECTED_ROWS[row].kind)
                ROW_WRITE:
                    write_modulus(DIRECTED_ROWS[row].value);
                ROW_KNOWN:
                    offer_operand(DIRECTED_ROWS[row].value, DIRECTED_ROWS[row].result);
                default:
                    offer_operand(DIRECTED_ROWS[row].value,
                                  predict_inverse(DIRECTED_ROWS[row].value, active_modulus));
            endcase
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // second phase: small modulus, back-to-back feed against a stalled receiver
            write_modulus((phase == 1) ? value_t'(97) : pick_modulus());
            if (phase == 1)
            begin
                steady_feed = 1'b1;
                holdoff_requests++;
            end
            phase_items = $urandom_range(40, 120);
            repeat (phase_items)
            begin
                operand = pick_operand(active_modulus);
                offer_operand(operand, predict_inverse(operand, active_modulus));
                sent++;
            end
            steady_feed = 1'b0;
            phase++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (pending_inverses.size() != 0)
        begin
            report_failure("missing transfer", pending_inverses.pop_front(), '0);
        end
        if (fail_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
